// ===== design/grade_valve_pid_drive_assert.svh =====
// Assertion macros for the grade valve PID drive.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef GRADE_VALVE_PID_DRIVE_ASSERT_SVH
`define GRADE_VALVE_PID_DRIVE_ASSERT_SVH

// Same-cycle implication.
`define GVPD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GVPD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gvpd_pkg.sv =====
// Shared types and constants for the grade valve PID drive.
// No dependencies; used by the input and configuration interfaces and the top level.
package gvpd_pkg;

    // Field widths of the channels.
    localparam int DIR_W      = 2;
    localparam int DELTA_W    = 8;
    localparam int AUTO_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int GAIN_W     = 8;
    localparam int KIND_W     = 2;

    // Internal datapath widths.
    localparam int ERR_W   = 9;
    localparam int DIFF_W  = 10;
    localparam int INTEG_W = 32;
    localparam int ACC_W   = 35;
    localparam int WHOLE_W = 13;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 64;
    localparam int DIVD_W  = 12;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_RAISE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LOWER = 2'd1;
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_IDLE  = 2'd3;

    // Auto mode value that enables the drive.
    localparam logic [AUTO_W-1:0] AUTO_ON = 8'd1;

    // Valve kind with the narrow limit window.
    localparam logic [KIND_W-1:0] KIND_NARROW = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_SMALL_BAND    = 3'd3,
        REG_RETRACT_BAND  = 3'd4,
        REG_EXTEND_BAND   = 3'd5,
        REG_VALVE_KIND    = 3'd6
    } cfg_reg_t;

    // Register reset values.
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN    = 8'd35;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN   = 8'd2;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN   = 8'd31;
    localparam logic [GAIN_W-1:0] RST_SMALL_BAND   = 8'd2;
    localparam logic [GAIN_W-1:0] RST_RETRACT_BAND = 8'd25;
    localparam logic [GAIN_W-1:0] RST_EXTEND_BAND  = 8'd75;
    localparam logic [KIND_W-1:0] RST_VALVE_KIND   = 2'd3;

    // Control constants: total clamp in hundredths and the map range in codes.
    localparam int TOTAL_LIMIT_H = 230000;
    localparam int TOTAL_RANGE   = 2300;
    localparam int P_SCALE       = 100;
    localparam int D_SCALE       = 200;
    localparam int BAND_DIV      = 200;

    // Constant divisors handled by the shared divider sequence.
    typedef enum logic [1:0] {
        DIV_HUND = 2'd0,
        DIV_BAND = 2'd1,
        DIV_MAP  = 2'd2
    } div_sel_t;

    // Sequencer states.
    typedef enum logic [17:0] {
        ST_IDLE     = 18'h00001,
        ST_P        = 18'h00002,
        ST_P100     = 18'h00004,
        ST_D        = 18'h00008,
        ST_D200     = 18'h00010,
        ST_INTEG    = 18'h00020,
        ST_SUM      = 18'h00040,
        ST_HLD      = 18'h00080,
        ST_DIV_MUL  = 18'h00100,
        ST_DIV_BACK = 18'h00200,
        ST_DIV_FIX  = 18'h00400,
        ST_WHOLE    = 18'h00800,
        ST_START    = 18'h01000,
        ST_SLOPE    = 18'h02000,
        ST_MAPLD    = 18'h04000,
        ST_CODE     = 18'h08000,
        ST_CLAMP    = 18'h10000,
        ST_OUT      = 18'h20000
    } gvpd_state_t;

endpackage

// ===== design/gvpd_in_if.sv =====
// Input channel of the grade valve PID drive: one control tick per word.
// Depends on gvpd_pkg for the field widths.
interface gvpd_in_if import gvpd_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [DIR_W-1:0]     direction_code;
    logic [DELTA_W-1:0]   cut_delta;
    logic [AUTO_W-1:0]    auto_mode;

    modport source (output valid, output direction_code, output cut_delta,
                    output auto_mode, input ready);
    modport sink (input valid, input direction_code, input cut_delta,
                  input auto_mode, output ready);

endinterface

// ===== design/gvpd_out_if.sv =====
// Output channel of the grade valve PID drive: one valve code per word.
// Stand-alone; the code width follows the DAC_BITS parameter.
interface gvpd_out_if #(
    parameter int DAC_BITS = 12
) ();

    logic                valid;
    logic                ready;
    logic [DAC_BITS-1:0] valve_code;
    logic                drive_engaged;

    modport source (output valid, output valve_code, output drive_engaged, input ready);
    modport sink (input valid, input valve_code, input drive_engaged, output ready);

endinterface

// ===== design/gvpd_cfg_if.sv =====
// Configuration write channel of the grade valve PID drive.
// Depends on gvpd_pkg for the index and data widths.
interface gvpd_cfg_if import gvpd_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

// ===== design/grade_valve_pid_drive.sv =====
// Grade valve PID drive: top level with a sequencer around one shared multiplier.
// Depends on gvpd_pkg, gvpd_in_if, gvpd_out_if, gvpd_cfg_if and the assertion macros.
//
// Usage:
// in_word carries one control tick (direction, cut delta, auto mode) per word.
// out_word returns exactly one word per tick: the valve code and the engaged flag.
// cfg writes one of seven registers per word; it is always ready and should only
// be used while no tick is in flight.
// A tick that is not engaged (auto mode not 1, or not cutting) goes from
// acceptance straight to the output state. An engaged tick that only updates
// state runs the P, D, integrator and sum steps; a tick that maps to a valve
// code adds the divisions and map steps; ready returns as that word is loaded.
// Each step is one pass through the single 32x32 signed multiplier or a narrow
// add, and each division by 100, 200 or 2300 takes three passes.
// in_word is ready only while the sequencer is idle; one tick is worked at a time.
// The output register holds a finished word while the receiver stalls, and the
// next tick may be accepted meanwhile; the sequencer waits in its last state
// only if a second result is ready before the first has been taken.
// Reset sets the registers to their defaults and clears the integrator and the
// last error; no output word is pending after reset.
`include "grade_valve_pid_drive_assert.svh"

module grade_valve_pid_drive import gvpd_pkg::*; #(
    parameter int DAC_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    gvpd_in_if.sink    in_word,
    gvpd_out_if.source out_word,
    gvpd_cfg_if.sink   cfg
);

    // Derived widths and constants.
    localparam int NW     = DAC_BITS + 12;
    localparam int CODE_W = DAC_BITS + 3;
    localparam int FULL   = 1 << DAC_BITS;
    localparam int FLOAT  = 1 << (DAC_BITS - 1);
    localparam int LO_WIDE   = (11 * FULL) / 100;
    localparam int HI_WIDE   = (89 * FULL) / 100;
    localparam int LO_NARROW = (26 * FULL) / 100;
    localparam int HI_NARROW = (74 * FULL) / 100;

    localparam logic [MUL_W-1:0] M_HUND = MUL_W'((64'd1 << NW) / P_SCALE);
    localparam logic [MUL_W-1:0] M_BAND = MUL_W'((64'd1 << NW) / BAND_DIV);
    localparam logic [MUL_W-1:0] M_MAP  = MUL_W'((64'd1 << NW) / TOTAL_RANGE);

    localparam logic signed [ACC_W-1:0] TOT_HI = ACC_W'(TOTAL_LIMIT_H);
    localparam logic signed [ACC_W-1:0] TOT_LO = -TOT_HI;
    localparam logic signed [CODE_W-1:0] FLOAT_C = CODE_W'(FLOAT);
    localparam logic [DAC_BITS-1:0] FLOAT_OUT = DAC_BITS'(FLOAT);

    // Configuration registers.
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;
    logic [GAIN_W-1:0] small_band_reg;
    logic [GAIN_W-1:0] retract_band_reg;
    logic [GAIN_W-1:0] extend_band_reg;
    logic [KIND_W-1:0] valve_kind_reg;

    // Controller state.
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ERR_W-1:0]   last_err_reg;

    // Sequencer and output control.
    gvpd_state_t state_reg, state_next;
    logic        out_valid_reg;

    // Working registers of the tick in flight.
    logic [DIR_W-1:0]          dir_reg;
    logic [DELTA_W-1:0]        delta_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic                      engaged_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [NW-1:0]             div_n_reg;
    logic                      div_neg_reg;
    div_sel_t                  div_sel_reg;
    logic [NW-1:0]             q_reg;
    logic signed [WHOLE_W-1:0] whole_reg;
    logic signed [CODE_W-1:0]  start_reg;
    logic signed [CODE_W-1:0]  slope_reg;
    logic signed [CODE_W-1:0]  code_reg;
    logic [DAC_BITS-1:0]       res_code_reg;
    logic [DAC_BITS-1:0]       out_code_reg;
    logic                      out_engaged_reg;

    // Combinational helpers.
    logic                      in_accept;
    logic                      out_free;
    logic                      is_lower;
    logic                      in_band;
    logic                      map_ok;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [DIVD_W-1:0]         div_d;
    logic [MUL_W-1:0]          div_m;
    logic signed [DIFF_W-1:0]  err_diff;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [ACC_W-1:0]   tot_sum;
    logic signed [ACC_W-1:0]   tot_clamp;
    logic [NW-1:0]             div_rem;
    logic signed [WHOLE_W-1:0] q_whole;
    logic signed [CODE_W-1:0]  q_code;
    logic signed [CODE_W-1:0]  lo_c;
    logic signed [CODE_W-1:0]  hi_c;
    logic [GAIN_W-1:0]         band_byte;
    logic signed [ERR_W-1:0]   in_err;

    // Handshakes.
    assign in_accept      = in_word.valid && in_word.ready;
    assign in_word.ready  = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign out_free       = !out_valid_reg || out_word.ready;

    assign out_word.valid         = out_valid_reg;
    assign out_word.valve_code    = out_code_reg;
    assign out_word.drive_engaged = out_engaged_reg;

    // Decisions on the tick in flight.
    assign is_lower = (dir_reg == DIR_LOWER);
    assign in_band  = (delta_reg < small_band_reg);
    assign map_ok   = ((dir_reg == DIR_RAISE) || (dir_reg == DIR_LOWER)) &&
                      (delta_reg >= small_band_reg);
    assign in_err   = (in_word.direction_code == DIR_RAISE) ?
                      signed'({1'b0, in_word.cut_delta}) :
                      -signed'({1'b0, in_word.cut_delta});
    assign err_diff = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);
    assign band_byte = is_lower ? retract_band_reg : extend_band_reg;

    // Valve limits for the configured valve kind.
    assign lo_c = (valve_kind_reg == KIND_NARROW) ? CODE_W'(LO_NARROW) : CODE_W'(LO_WIDE);
    assign hi_c = (valve_kind_reg == KIND_NARROW) ? CODE_W'(HI_NARROW) : CODE_W'(HI_WIDE);

    // Divisor and reciprocal of the division in progress.
    always_comb
    begin
        unique case (div_sel_reg)
            DIV_HUND:
            begin
                div_d = DIVD_W'(P_SCALE);
                div_m = M_HUND;
            end
            DIV_BAND:
            begin
                div_d = DIVD_W'(BAND_DIV);
                div_m = M_BAND;
            end
            DIV_MAP:
            begin
                div_d = DIVD_W'(TOTAL_RANGE);
                div_m = M_MAP;
            end
            default:
            begin
                div_d = DIVD_W'(TOTAL_RANGE);
                div_m = M_MAP;
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_P:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(prop_gain_reg);
            end
            ST_P100:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(P_SCALE);
            end
            ST_D:
            begin
                mul_a = MUL_W'(err_diff);
                mul_b = MUL_W'(deriv_gain_reg);
            end
            ST_D200:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(D_SCALE);
            end
            ST_INTEG:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(integ_gain_reg);
            end
            ST_SLOPE:
            begin
                mul_a = MUL_W'(whole_reg);
                mul_b = MUL_W'(slope_reg);
            end
            ST_DIV_MUL:
            begin
                mul_a = MUL_W'(div_n_reg);
                mul_b = div_m;
            end
            ST_DIV_BACK:
            begin
                mul_a = MUL_W'(prod_reg[NW +: NW]);
                mul_b = MUL_W'(div_d);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Integrator add, total add and clamp, divider correction.
    assign integ_sum = (INTEG_W + 1)'(integ_reg) + mul_p[INTEG_W:0];
    assign tot_sum   = acc_reg + ACC_W'(integ_reg);
    assign tot_clamp = (tot_sum > TOT_HI) ? TOT_HI :
                       (tot_sum < TOT_LO) ? TOT_LO : tot_sum;
    assign div_rem   = div_n_reg - prod_reg[NW-1:0];
    assign q_whole   = signed'(WHOLE_W'(q_reg));
    assign q_code    = signed'(CODE_W'(q_reg));

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((in_word.auto_mode == AUTO_ON) && (in_word.direction_code != DIR_IDLE))
                        state_next = ST_P;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_P:        state_next = ST_P100;
            ST_P100:     state_next = ST_D;
            ST_D:        state_next = ST_D200;
            ST_D200:     state_next = ST_INTEG;
            ST_INTEG:    state_next = ST_SUM;
            ST_SUM:      state_next = map_ok ? ST_HLD : ST_OUT;
            ST_HLD:      state_next = ST_DIV_MUL;
            ST_DIV_MUL:  state_next = ST_DIV_BACK;
            ST_DIV_BACK: state_next = ST_DIV_FIX;
            ST_DIV_FIX:
            begin
                unique case (div_sel_reg)
                    DIV_HUND: state_next = ST_WHOLE;
                    DIV_BAND: state_next = ST_START;
                    DIV_MAP:  state_next = ST_CODE;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_WHOLE:    state_next = ST_DIV_MUL;
            ST_START:    state_next = ST_SLOPE;
            ST_SLOPE:    state_next = ST_MAPLD;
            ST_MAPLD:    state_next = ST_DIV_MUL;
            ST_CODE:     state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control registers: sequencer state, output valid, configuration and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            prop_gain_reg    <= RST_PROP_GAIN;
            integ_gain_reg   <= RST_INTEG_GAIN;
            deriv_gain_reg   <= RST_DERIV_GAIN;
            small_band_reg   <= RST_SMALL_BAND;
            retract_band_reg <= RST_RETRACT_BAND;
            extend_band_reg  <= RST_EXTEND_BAND;
            valve_kind_reg   <= RST_VALVE_KIND;
            integ_reg        <= '0;
            last_err_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_word.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_PROP_GAIN:    prop_gain_reg    <= cfg.data;
                    REG_INTEG_GAIN:   integ_gain_reg   <= cfg.data;
                    REG_DERIV_GAIN:   deriv_gain_reg   <= cfg.data;
                    REG_SMALL_BAND:   small_band_reg   <= cfg.data;
                    REG_RETRACT_BAND: retract_band_reg <= cfg.data;
                    REG_EXTEND_BAND:  extend_band_reg  <= cfg.data;
                    REG_VALVE_KIND:   valve_kind_reg   <= cfg.data[KIND_W-1:0];
                    default:          ;
                endcase
            end

            // The integrator runs only inside the small error band and saturates.
            if (state_reg == ST_INTEG)
            begin
                last_err_reg <= err_reg;
                if (!in_band)
                    integ_reg <= '0;
                else if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
                    integ_reg <= integ_sum[INTEG_W] ?
                                 {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
                else
                    integ_reg <= integ_sum[INTEG_W-1:0];
            end
        end
    end

    // Datapath registers of the tick in flight.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (state_reg == ST_OUT && out_free)
        begin
            out_code_reg    <= res_code_reg;
            out_engaged_reg <= engaged_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    dir_reg      <= in_word.direction_code;
                    delta_reg    <= in_word.cut_delta;
                    err_reg      <= in_err;
                    engaged_reg  <= (in_word.auto_mode == AUTO_ON) &&
                                    (in_word.direction_code != DIR_IDLE);
                    res_code_reg <= FLOAT_OUT;
                end
            end
            ST_P100:  acc_reg <= mul_p[ACC_W-1:0];
            ST_D200:  acc_reg <= acc_reg + mul_p[ACC_W-1:0];
            ST_SUM:   acc_reg <= tot_clamp;
            // Divide the clamped total by 100, truncating toward zero.
            ST_HLD:
            begin
                div_n_reg   <= NW'(acc_reg[ACC_W-1] ? -acc_reg : acc_reg);
                div_neg_reg <= acc_reg[ACC_W-1];
                div_sel_reg <= DIV_HUND;
            end
            ST_DIV_BACK: q_reg <= prod_reg[NW +: NW];
            ST_DIV_FIX:
            begin
                if (div_rem >= NW'(div_d))
                    q_reg <= q_reg + NW'(1);
            end
            // Whole codes known; now derive the deadband offset byte*2^B/200.
            ST_WHOLE:
            begin
                whole_reg   <= div_neg_reg ? -q_whole : q_whole;
                div_n_reg   <= NW'({band_byte, {DAC_BITS{1'b0}}});
                div_neg_reg <= 1'b0;
                div_sel_reg <= DIV_BAND;
            end
            // Window start and the span from it to the valve limit.
            ST_START:
            begin
                if (is_lower)
                begin
                    start_reg <= FLOAT_C - q_code;
                    slope_reg <= lo_c - FLOAT_C + q_code;
                end
                else
                begin
                    start_reg <= FLOAT_C + q_code;
                    slope_reg <= hi_c - FLOAT_C - q_code;
                end
            end
            // Scale whole*span down by the map range.
            ST_MAPLD:
            begin
                div_n_reg   <= NW'(prod_reg[PROD_W-1] ? -prod_reg : prod_reg);
                div_neg_reg <= prod_reg[PROD_W-1];
                div_sel_reg <= DIV_MAP;
            end
            // The retract map divides by the negated range, which flips the sign.
            ST_CODE:
            begin
                code_reg <= (div_neg_reg ^ is_lower) ? start_reg - q_code : start_reg + q_code;
            end
            ST_CLAMP:
            begin
                if (code_reg < lo_c)
                    res_code_reg <= DAC_BITS'(lo_c);
                else if (code_reg > hi_c)
                    res_code_reg <= DAC_BITS'(hi_c);
                else
                    res_code_reg <= DAC_BITS'(code_reg);
            end
            default: ;
        endcase
    end

    // Checks.
    `GVPD_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_word.ready,
        "input accepted while a tick is still in flight")
    `GVPD_ASSERT_IMPL(a_idle_floats, out_word.valid && !out_word.drive_engaged,
        out_word.valve_code == FLOAT_OUT, "disengaged word does not float")
    `GVPD_ASSERT_IMPL(a_code_in_limits, out_word.valid && out_word.valve_code != FLOAT_OUT,
        out_word.valve_code >= DAC_BITS'(LO_WIDE) && out_word.valve_code <= DAC_BITS'(HI_WIDE),
        "valve code outside the valve limits")
    `GVPD_ASSERT_NEXT(a_integ_cleared, state_reg == ST_INTEG && !in_band,
        integ_reg == '0, "integrator not cleared outside the small error band")

endmodule
